@@ hw/rtl/rrpq_pkg.sv @@
// Shared types and constants for the request/reply packet queue.
// No dependencies; imported by every module of the block.
package rrpq_pkg;

  localparam int DEPTH     = 16;
  localparam int NODE_BITS = 8;
  localparam int PTR_W     = 4;
  localparam int CNT_W     = 5;
  localparam int LIMIT_W   = 5;
  localparam int DELAY_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]   CNT_DEPTH = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [DELAY_W-1:0] TIMER_MAX = '1;

  // Packet type codes
  localparam logic PKT_REQUEST = 1'b1;
  localparam logic PKT_DEFAULT = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_ISSUE = 2'd1,
    OP_REPLY = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUEUE_LIMIT = 1'd0,
    CFG_DELAY_TICKS = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic                 is_req;
    logic [NODE_BITS-1:0] dest;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input beat and read the head entry
    logic exec;  // apply the operation and load the result register
  } cmd_t;

endpackage

@@ hw/rtl/rrpq_ctrl.sv @@
// Sequencing controller for the request/reply packet queue.
// Depends on rrpq_pkg; drives the datapath through cmd_t.
module rrpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output rrpq_pkg::cmd_t      cmd
);
  import rrpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.exec  = (state_r == S_EXEC) && out_free;

  // Next state and result-valid tracking
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Exec always leaves a beat waiting in the result register
  a_exec_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("result register empty after exec");

  // A held result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.exec)
    else $error("exec while result stalled");

endmodule

@@ hw/rtl/rrpq_dp.sv @@
// Datapath for the request/reply packet queue: packet store, pointers,
// counters, wait timer, configuration and result register. Uses rrpq_pkg.
module rrpq_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rrpq_pkg::cmd_t                  cmd,
  input  logic                            cfg_we,
  input  logic [rrpq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rrpq_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic [1:0]                      in_req_type,
  input  logic                            in_pkt_is_request,
  input  logic [rrpq_pkg::NODE_BITS-1:0]  in_pkt_dest,
  input  logic [rrpq_pkg::NODE_BITS-1:0]  in_reply_src,
  output logic                            out_accepted,
  output logic                            out_not_full,
  output logic                            out_issued_valid,
  output logic                            out_issued_is_request,
  output logic [rrpq_pkg::NODE_BITS-1:0]  out_issued_dest,
  output logic [rrpq_pkg::CNT_W-1:0]      out_occupancy,
  output logic [rrpq_pkg::CNT_W-1:0]      out_pending_requests,
  output logic [rrpq_pkg::CNT_W-1:0]      out_defaults_to_clear
);
  import rrpq_pkg::*;

  entry_t               mem [DEPTH];

  // Captured beat and head entry
  op_t                  op_r;
  entry_t               new_r;
  logic [NODE_BITS-1:0] src_r;
  entry_t               head_r;

  // Queue state
  logic [PTR_W-1:0]     head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0]     tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 active_r, active_nxt;
  logic [DELAY_W-1:0]   timer_r, timer_nxt;
  logic [CNT_W-1:0]     req_cnt_r, req_cnt_nxt;
  logic [CNT_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [DELAY_W-1:0]   delay_r;

  // Result register
  logic                 acc_r, acc_nxt;
  logic                 nf_r;
  logic                 iv_r, iv_nxt;
  entry_t               iss_r, iss_nxt;

  logic                 has_room;
  logic                 wr_en;
  logic [DELAY_W-1:0]   timer_inc;

  // Room below the effective limit, min(queue_limit, DEPTH)
  assign has_room = (count_r < CNT_W'(limit_r)) && (count_r < CNT_DEPTH);

  // Apply one operation
  always_comb begin
    head_ptr_nxt = head_ptr_r;
    tail_ptr_nxt = tail_ptr_r;
    count_nxt    = count_r;
    active_nxt   = active_r;
    timer_nxt    = timer_r;
    req_cnt_nxt  = req_cnt_r;
    clr_cnt_nxt  = clr_cnt_r;
    acc_nxt      = 1'b0;
    iv_nxt       = 1'b0;
    iss_nxt      = '0;
    wr_en        = 1'b0;
    timer_inc    = (active_r && timer_r != TIMER_MAX) ? timer_r + 1'b1 : timer_r;
    case (op_r)
      OP_PUSH: begin
        if (has_room) begin
          wr_en        = 1'b1;
          tail_ptr_nxt = (tail_ptr_r == PTR_LAST) ? '0 : tail_ptr_r + 1'b1;
          count_nxt    = count_r + 1'b1;
          acc_nxt      = 1'b1;
        end
      end
      OP_ISSUE: begin
        if (count_r != '0 && !active_r) begin
          iv_nxt     = 1'b1;
          iss_nxt    = head_r;
          active_nxt = 1'b1;
          if (head_r.is_req == PKT_REQUEST) begin
            req_cnt_nxt = (req_cnt_r == CNT_MAX) ? req_cnt_r : req_cnt_r + 1'b1;
          end else begin
            clr_cnt_nxt = (clr_cnt_r == CNT_MAX) ? clr_cnt_r : clr_cnt_r + 1'b1;
          end
        end
      end
      OP_REPLY: begin
        if (count_r != '0 && active_r && head_r.dest == src_r) begin
          head_ptr_nxt = (head_ptr_r == PTR_LAST) ? '0 : head_ptr_r + 1'b1;
          count_nxt    = count_r - 1'b1;
          active_nxt   = 1'b0;
          req_cnt_nxt  = (req_cnt_r == '0) ? '0 : req_cnt_r - 1'b1;
          acc_nxt      = 1'b1;
        end
      end
      OP_TICK: begin
        timer_nxt = timer_inc;
        if (count_r == '0) begin
          timer_nxt = '0;
        end else if (timer_inc >= delay_r) begin
          // Pop a default head on timeout; timer restarts either way
          if (head_r.is_req == PKT_DEFAULT) begin
            head_ptr_nxt = (head_ptr_r == PTR_LAST) ? '0 : head_ptr_r + 1'b1;
            count_nxt    = count_r - 1'b1;
            active_nxt   = 1'b0;
            clr_cnt_nxt  = (clr_cnt_r == '0) ? '0 : clr_cnt_r - 1'b1;
          end
          timer_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Capture the beat and read the head entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= op_t'(in_req_type);
      new_r       <= '{is_req: in_pkt_is_request, dest: in_pkt_dest};
      src_r       <= in_reply_src;
      head_r      <= mem[head_ptr_r];
    end
  end

  // Write the packet store at the tail
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[tail_ptr_r] <= new_r;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r <= acc_nxt;
      nf_r  <= (count_nxt < CNT_W'(limit_r)) && (count_nxt < CNT_DEPTH);
      iv_r  <= iv_nxt;
      iss_r <= iss_nxt;
    end
  end

  // Queue state, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ptr_r <= '0;
      tail_ptr_r <= '0;
      count_r    <= '0;
      active_r   <= 1'b0;
      timer_r    <= '0;
      req_cnt_r  <= '0;
      clr_cnt_r  <= '0;
      limit_r    <= LIMIT_W'(16);
      delay_r    <= DELAY_W'(1);
    end else begin
      if (cmd.exec) begin
        head_ptr_r <= head_ptr_nxt;
        tail_ptr_r <= tail_ptr_nxt;
        count_r    <= count_nxt;
        active_r   <= active_nxt;
        timer_r    <= timer_nxt;
        req_cnt_r  <= req_cnt_nxt;
        clr_cnt_r  <= clr_cnt_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_QUEUE_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
          CFG_DELAY_TICKS: delay_r <= cfg_wdata[DELAY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_accepted          = acc_r;
  assign out_not_full          = nf_r;
  assign out_issued_valid      = iv_r;
  assign out_issued_is_request = iss_r.is_req;
  assign out_issued_dest       = iss_r.dest;
  assign out_occupancy         = count_r;
  assign out_pending_requests  = req_cnt_r;
  assign out_defaults_to_clear = clr_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_DEPTH)
    else $error("occupancy beyond store depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_ptr_r == tail_ptr_r))
    else $error("empty queue with unequal pointers");

  a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (count_r != '0))
    else $error("active head on empty queue");

endmodule

@@ hw/rtl/request_reply_packet_queue.sv @@
// Request/reply packet queue, top level. Depends on rrpq_pkg, rrpq_ctrl, rrpq_dp.
// Each item is captured with a registered head-entry read, then applied and
// loaded into the result register once that is free; in_stall holds off the
// next item until then, and it may enter while a result waits in the register.
// Reset (rst_n, synchronous): queue empty, counters and timer zero, queue_limit 16,
// delay_ticks 1; the packet store is not cleared.
module request_reply_packet_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rrpq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rrpq_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic                            in_pkt_is_request,
  input  logic [rrpq_pkg::NODE_BITS-1:0]  in_pkt_dest,
  input  logic [rrpq_pkg::NODE_BITS-1:0]  in_reply_src,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic                            out_not_full,
  output logic                            out_issued_valid,
  output logic                            out_issued_is_request,
  output logic [rrpq_pkg::NODE_BITS-1:0]  out_issued_dest,
  output logic [rrpq_pkg::CNT_W-1:0]      out_occupancy,
  output logic [rrpq_pkg::CNT_W-1:0]      out_pending_requests,
  output logic [rrpq_pkg::CNT_W-1:0]      out_defaults_to_clear
);
  import rrpq_pkg::*;

  cmd_t cmd;

  rrpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rrpq_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_we),
    .cfg_idx               (cfg_idx),
    .cfg_wdata             (cfg_wdata),
    .in_req_type           (in_req_type),
    .in_pkt_is_request     (in_pkt_is_request),
    .in_pkt_dest           (in_pkt_dest),
    .in_reply_src          (in_reply_src),
    .out_accepted          (out_accepted),
    .out_not_full          (out_not_full),
    .out_issued_valid      (out_issued_valid),
    .out_issued_is_request (out_issued_is_request),
    .out_issued_dest       (out_issued_dest),
    .out_occupancy         (out_occupancy),
    .out_pending_requests  (out_pending_requests),
    .out_defaults_to_clear (out_defaults_to_clear)
  );

endmodule
